### rtl/lpcd_pkg.sv
// ----------------------------------------------------------------------------
// lpcd_pkg
// Shared types, constants and code tables of the LSB-first prefix decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcd_pkg;

  localparam int MaxCodeLen = 6;
  localparam int BufBits    = 13;
  localparam int HeldBits   = 4;
  localparam int CntBits    = 16;
  localparam int LimitBits  = 16;
  localparam int AddrBits   = 3;
  localparam logic [LimitBits-1:0] LimitReset = 16'd255;
  localparam logic                 RegSymbolLimit = 1'b0;

  typedef enum logic [2:0] {
    KIND_SYMBOL     = 3'd0,
    KIND_END        = 3'd1,
    KIND_INCOMPLETE = 3'd2,
    KIND_EXHAUSTED  = 3'd3,
    KIND_LIMIT      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // decode of the code at the bottom of the bit buffer
  typedef struct packed {
    logic [2:0] ones;
    logic [2:0] len;
    logic       complete;
    logic       is_end;
  } dec_t;

  typedef struct packed {
    logic load;
    logic consume;
    logic clear;
  } bb_cmd_t;

  typedef struct packed {
    logic held_zero;
    dec_t cur;
    logic nxt_held_zero;
    logic nxt_complete;
  } bb_stat_t;

  function automatic dec_t code_decode(input logic [BufBits-1:0]  bits,
                                       input logic [HeldBits-1:0] held);
    dec_t d;
    logic run;
    d.ones = '0;
    run    = 1'b1;
    for (int i = 0; i < MaxCodeLen; i++) begin
      if (run && (HeldBits'(i) < held) && bits[i]) begin
        d.ones = d.ones + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
    d.is_end   = (d.ones == 3'(MaxCodeLen));
    d.len      = d.is_end ? 3'(MaxCodeLen) : d.ones + 3'd1;
    d.complete = (HeldBits'(d.len) <= held);
    return d;
  endfunction

  function automatic logic [7:0] sym_char(input logic [2:0] ones);
    logic [7:0] c;
    unique case (ones)
      3'd0:    c = 8'h65;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h20;
      3'd4:    c = 8'h68;
      3'd5:    c = 8'h72;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/lpcd_if.sv
// ----------------------------------------------------------------------------
// lpcd stream interfaces
// Valid/ready channels for encoded input words and decoded result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       final_byte;

  modport source (output valid, output stream_byte, output final_byte, input ready);
  modport sink   (input valid, input stream_byte, input final_byte, output ready);
endinterface

interface lpcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic [2:0] result_kind;
  logic       run_end;

  modport source (output valid, output character, output result_kind, output run_end,
                  input ready);
  modport sink   (input valid, input character, input result_kind, input run_end,
                  output ready);
endinterface

`default_nettype wire

### rtl/lsb_first_prefix_code_decoder_top.sv
// ----------------------------------------------------------------------------
// lsb_first_prefix_code_decoder_top
// Decodes an LSB-first prefix-coded word stream into characters and markers.
// ----------------------------------------------------------------------------
// Flow: an accepted word is loaded into the bit shift register; its results
//   are then decoded into the result register. No new word is taken until
//   the last one is done. One code leaves the bit shift register per cycle and
//   the result register one word per cycle while the receiver is ready.
// Reset: synchronous, active low; clears the run state, limit returns to 255.
`default_nettype none

module lsb_first_prefix_code_decoder_top
  import lpcd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  lpcd_in_if.sink                  in_chan,
  lpcd_out_if.source               out_chan,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  logic [LimitBits-1:0] symbol_limit;
  bb_cmd_t              bb_cmd;
  bb_stat_t             bb_stat;

  state_t               state_r, state_nxt;
  logic [CntBits-1:0]   cnt_r, cnt_nxt, cnt_sat;
  logic                 stop_r, stop_nxt;
  logic                 fin_r, fin_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           char_r, char_nxt;
  kind_t                kind_r, kind_nxt;
  logic                 run_end_r, run_end_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic                 emit;
  logic                 finish;
  logic                 nxt_has;

  lpcd_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .symbol_limit (symbol_limit)
  );

  lpcd_bitbuf u_bitbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (bb_cmd),
    .data_in (in_chan.stream_byte),
    .stat    (bb_stat)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign cnt_sat       = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
  // after this symbol, does the next step give a result for the same word
  assign nxt_has       = (cnt_sat >= symbol_limit) || fin_r ||
                         (!bb_stat.nxt_held_zero && bb_stat.nxt_complete);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    stop_nxt    = stop_r;
    fin_nxt     = fin_r;
    bb_cmd      = '0;
    emit        = 1'b0;
    finish      = 1'b0;
    char_nxt    = 8'h00;
    kind_nxt    = KIND_SYMBOL;
    run_end_nxt = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (stop_r) begin
            // drop words until the final one, which clears the run
            if (in_chan.final_byte) begin
              bb_cmd.clear = 1'b1;
              cnt_nxt      = '0;
              stop_nxt     = 1'b0;
            end
          end else begin
            bb_cmd.load = 1'b1;
            fin_nxt     = in_chan.final_byte;
            state_nxt   = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          if (cnt_r >= symbol_limit) begin
            emit     = 1'b1;
            kind_nxt = KIND_LIMIT;
            stop_nxt = 1'b1;
            finish   = 1'b1;
          end else if (bb_stat.held_zero) begin
            emit     = fin_r;
            kind_nxt = KIND_EXHAUSTED;
            finish   = 1'b1;
          end else if (!bb_stat.cur.complete) begin
            // hold partial code bits for the next word unless stream ends
            emit     = fin_r;
            kind_nxt = KIND_INCOMPLETE;
            finish   = 1'b1;
          end else if (bb_stat.cur.is_end) begin
            bb_cmd.consume = 1'b1;
            emit           = 1'b1;
            kind_nxt       = KIND_END;
            stop_nxt       = 1'b1;
            finish         = 1'b1;
          end else begin
            bb_cmd.consume = 1'b1;
            emit           = 1'b1;
            char_nxt       = sym_char(bb_stat.cur.ones);
            kind_nxt       = KIND_SYMBOL;
            run_end_nxt    = !nxt_has;
            cnt_nxt        = cnt_sat;
            if (nxt_has) begin
              state_nxt = ST_RUN;
            end
          end
          if (finish && fin_r) begin
            bb_cmd.clear = 1'b1;
            cnt_nxt      = '0;
            stop_nxt     = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      stop_r      <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      stop_r      <= stop_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r    <= char_nxt;
      kind_r    <= kind_nxt;
      run_end_r <= run_end_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.character   = char_r;
  assign out_chan.result_kind = kind_r;
  assign out_chan.run_end     = run_end_r;

  // markers always close the results of their word
  a_marker_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r != KIND_SYMBOL)) |-> run_end_r)
    else $error("marker result without run_end");

  a_marker_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r != KIND_SYMBOL)) |-> (char_r == 8'h00))
    else $error("marker result carries a character");

  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RUN))
    else $error("result raised outside the decode state");

endmodule

`default_nettype wire

### rtl/lpcd_cfg.sv
// ----------------------------------------------------------------------------
// lpcd_cfg
// APB register file holding the symbol limit.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcd_cfg
  import lpcd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrBits-1:0]  paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  output logic      [LimitBits-1:0] symbol_limit
);

  logic [LimitBits-1:0] limit_r;
  logic [LimitBits-1:0] limit_nxt;
  logic                 hit;

  assign hit    = (paddr[AddrBits-1] == RegSymbolLimit);
  assign pready = 1'b1;

  always_comb begin
    limit_nxt = limit_r;
    if (psel && penable && pwrite && hit) begin
      limit_nxt = pwdata[LimitBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LimitReset;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  assign prdata       = hit ? {{(32-LimitBits){1'b0}}, limit_r} : 32'd0;
  assign symbol_limit = limit_r;

endmodule

`default_nettype wire

### rtl/lpcd_bitbuf.sv
// ----------------------------------------------------------------------------
// lpcd_bitbuf
// Bit shift register: appends a word above held bits and, on consume, shifts
// one code out of the bottom per cycle; decodes the current and next code.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcd_bitbuf
  import lpcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire bb_cmd_t    cmd,
  input  wire logic [7:0] data_in,
  output bb_stat_t        stat
);

  logic [BufBits-1:0]  buf_r;
  logic [BufBits-1:0]  buf_nxt;
  logic [HeldBits-1:0] held_r;
  logic [HeldBits-1:0] held_nxt;
  logic [BufBits-1:0]  shifted;
  logic [HeldBits-1:0] held_after;
  logic [BufBits-1:0]  appended;
  dec_t                dec_cur;
  dec_t                dec_nxt;

  always_comb begin
    dec_cur    = code_decode(buf_r, held_r);
    shifted    = buf_r >> dec_cur.len;
    held_after = held_r - HeldBits'(dec_cur.len);
    dec_nxt    = code_decode(shifted, held_after);
    // held bits never exceed five here, so the word lands inside the buffer
    appended   = buf_r | (BufBits'(data_in) << held_r[2:0]);
  end

  always_comb begin
    buf_nxt  = buf_r;
    held_nxt = held_r;
    if (cmd.clear) begin
      buf_nxt  = '0;
      held_nxt = '0;
    end else if (cmd.load) begin
      buf_nxt  = appended;
      held_nxt = held_r + HeldBits'(8);
    end else if (cmd.consume) begin
      buf_nxt  = shifted;
      held_nxt = held_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= '0;
      held_r <= '0;
    end else begin
      buf_r  <= buf_nxt;
      held_r <= held_nxt;
    end
  end

  assign stat.held_zero     = (held_r == '0);
  assign stat.cur           = dec_cur;
  assign stat.nxt_held_zero = (held_after == '0);
  assign stat.nxt_complete  = dec_nxt.complete;

endmodule

`default_nettype wire

### sim/lsb_first_prefix_code_decoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsb_first_prefix_code_decoder_top_tb
// Self-checking bench for the LSB-first prefix decoder. A directed table
// covers code extremes, end/incomplete/exhausted/limit results and stopped
// runs. Random prefix-coded messages with random limits, idling on both
// channels and a long receiver hold follow. Every result word is compared
// with an in-bench model.
// ----------------------------------------------------------------------------

module lsb_first_prefix_code_decoder_top_tb;
  import lpcd_pkg::*;

  localparam int                  DrainCycles = 12;
  localparam int                  HoldCycles  = 300;
  localparam int                  PhaseWords  = 15;
  localparam logic [AddrBits-1:0] LimitAddr   = AddrBits'(4 * RegSymbolLimit);

  typedef struct packed {
    logic [7:0] character;
    kind_t      kind;
    logic       run_end;
  } result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } word_t;

  // one row of the directed table: a limit write or a word, with an optional
  // typed-in result count and last result
  typedef struct packed {
    logic        is_cfg;
    logic [15:0] limit;
    logic [7:0]  data;
    logic        fin;
    logic        known;
    logic [3:0]  count;
    kind_t       last_kind;
    logic [7:0]  last_char;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrBits-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  lpcd_in_if  in_bus ();
  lpcd_out_if out_bus ();

  lsb_first_prefix_code_decoder_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder model state
  logic [BufBits-1:0]   buf_bits;
  logic [HeldBits-1:0]  buf_count;
  logic [CntBits-1:0]   sym_count;
  logic                 halted;
  logic [LimitBits-1:0] limit_reg;

  result_t pending_results[$];
  word_t   word_plan[$];
  row_t    plan[$];
  int      mismatches = 0;
  logic    idle_on;
  logic    out_hold;
  event    hold_start;

  task automatic flag_error(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
  endtask

  function automatic logic [7:0] char_for(input int ones);
    case (ones)
      0:       return "e";
      1:       return "t";
      2:       return "a";
      3:       return " ";
      4:       return "h";
      default: return "r";
    endcase
  endfunction

  // decode one accepted word and queue the result words it causes
  function automatic int decode_word(input logic [7:0] data, input logic fin);
    result_t batch[$];
    result_t r;
    int      ones;
    int      len;
    logic    done;
    done = 1'b0;
    if (!halted) begin
      buf_bits  = buf_bits | (BufBits'(data) << buf_count[2:0]);
      buf_count = buf_count + 4'd8;
      while (!done) begin
        r = '{character: 8'h00, kind: KIND_SYMBOL, run_end: 1'b0};
        if (sym_count >= limit_reg) begin
          r.kind = KIND_LIMIT;
          batch.push_back(r);
          halted = 1'b1;
          done   = 1'b1;
        end else if (buf_count == '0) begin
          if (fin) begin
            r.kind = KIND_EXHAUSTED;
            batch.push_back(r);
          end
          done = 1'b1;
        end else begin
          ones = 0;
          while (ones < MaxCodeLen && ones < int'(buf_count) && buf_bits[ones]) begin
            ones++;
          end
          len = (ones < MaxCodeLen) ? ones + 1 : MaxCodeLen;
          if (len > int'(buf_count)) begin
            // keep the partial code unless the stream closes here
            if (fin) begin
              r.kind = KIND_INCOMPLETE;
              batch.push_back(r);
            end
            done = 1'b1;
          end else begin
            buf_bits  = buf_bits >> len;
            buf_count = buf_count - HeldBits'(len);
            if (ones == MaxCodeLen) begin
              r.kind = KIND_END;
              batch.push_back(r);
              halted = 1'b1;
              done   = 1'b1;
            end else begin
              r.character = char_for(ones);
              batch.push_back(r);
              if (sym_count != '1) begin
                sym_count = sym_count + 1'b1;
              end
            end
          end
        end
      end
    end
    if (batch.size() > 0) begin
      batch[batch.size()-1].run_end = 1'b1;
    end
    foreach (batch[i]) begin
      pending_results.push_back(batch[i]);
    end
    if (fin) begin
      buf_bits  = '0;
      buf_count = '0;
      sym_count = '0;
      halted    = 1'b0;
    end
    return batch.size();
  endfunction

  // append one message: mostly symbols closed by the end code, sometimes cut
  // inside a code, sometimes plain noise
  function automatic void build_message();
    bit    bits[$];
    word_t w;
    int    choice;
    int    k;
    choice = $urandom_range(0, 99);
    if (choice < 15) begin
      repeat ($urandom_range(1, 4)) begin
        w.data = 8'($urandom);
        w.fin  = ($urandom_range(0, 3) == 0);
        word_plan.push_back(w);
      end
      return;
    end
    repeat ($urandom_range(0, 12)) begin
      k = $urandom_range(0, MaxCodeLen - 1);
      repeat (k) bits.push_back(1'b1);
      bits.push_back(1'b0);
    end
    if (choice < 80) begin
      repeat (MaxCodeLen) bits.push_back(1'b1);
    end else if (choice < 90) begin
      repeat ($urandom_range(1, MaxCodeLen - 1)) bits.push_back(1'b1);
    end
    if (bits.size() == 0) begin
      bits.push_back(1'($urandom));
    end
    while (bits.size() % 8 != 0) begin
      bits.push_back(1'($urandom));
    end
    for (int i = 0; i < bits.size(); i += 8) begin
      for (int j = 0; j < 8; j++) begin
        w.data[j] = bits[i+j];
      end
      w.fin = (i + 8 >= bits.size());
      word_plan.push_back(w);
    end
  endfunction

  function automatic row_t word_row(input logic [7:0] data, input logic fin,
                                    input logic known, input int count,
                                    input kind_t last_kind, input logic [7:0] last_char);
    row_t r;
    r = '0;
    r.data      = data;
    r.fin       = fin;
    r.known     = known;
    r.count     = 4'(count);
    r.last_kind = last_kind;
    r.last_char = last_char;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [15:0] limit);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.limit  = limit;
    return r;
  endfunction

  // offer one word, hold it until taken, then predict its results
  task automatic push_word(input logic [7:0] data, input logic fin, output int produced);
    if (idle_on && $urandom_range(0, 99) < 36) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 36);
    end
    in_bus.valid       <= 1'b1;
    in_bus.stream_byte <= data;
    in_bus.final_byte  <= fin;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    produced = decode_word(data, fin);
  endtask

  // drop valid, let every expected word arrive, then let the block settle
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LimitAddr;
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== value) begin
      flag_error($sformatf("limit readback exp %0d got %0d", value, prdata[15:0]));
    end
    psel      <= 1'b0;
    penable   <= 1'b0;
    limit_reg = value;
  endtask

  // result side: check every accepted word, stall at random or on a hold
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected word char %h kind %0d end %b", out_bus.character,
                             out_bus.result_kind, out_bus.run_end));
      end else begin
        want = pending_results.pop_front();
        if (out_bus.character !== want.character || out_bus.result_kind !== want.kind ||
            out_bus.run_end !== want.run_end) begin
          flag_error($sformatf("exp char %h kind %0d end %b, got char %h kind %0d end %b",
                               want.character, want.kind, want.run_end, out_bus.character,
                               out_bus.result_kind, out_bus.run_end));
        end
      end
    end
    out_bus.ready <= !out_hold && !(idle_on && $urandom_range(0, 99) < 36);
  end

  // long receiver hold, counted here while the sender keeps offering
  initial begin
    out_hold = 1'b0;
    forever begin
      @(hold_start);
      out_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clk);
      out_hold <= 1'b0;
    end
  end

  initial begin
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int    got;
    word_t w;
    logic [15:0] lim;
    rst_n              = 1'b0;
    idle_on            = 1'b1;
    in_bus.valid       = 1'b0;
    in_bus.stream_byte = 8'h00;
    in_bus.final_byte  = 1'b0;
    out_bus.ready      = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    buf_bits           = '0;
    buf_count          = '0;
    sym_count          = '0;
    halted             = 1'b0;
    limit_reg          = LimitReset;

    plan = '{
      word_row(8'hFF, 1'b1, 1'b1, 1, KIND_END,        8'h00),
      word_row(8'h00, 1'b1, 1'b1, 9, KIND_EXHAUSTED,  8'h00),
      word_row(8'h3F, 1'b1, 1'b1, 1, KIND_END,        8'h00),
      word_row(8'h7F, 1'b0, 1'b1, 1, KIND_END,        8'h00),
      word_row(8'h00, 1'b0, 1'b1, 0, KIND_SYMBOL,     8'h00),
      word_row(8'h55, 1'b1, 1'b1, 0, KIND_SYMBOL,     8'h00),
      word_row(8'h1F, 1'b0, 1'b0, 0, KIND_SYMBOL,     8'h00),
      word_row(8'h01, 1'b1, 1'b0, 0, KIND_SYMBOL,     8'h00),
      word_row(8'h80, 1'b0, 1'b0, 0, KIND_SYMBOL,     8'h00),
      word_row(8'h07, 1'b1, 1'b0, 0, KIND_SYMBOL,     8'h00),
      word_row(8'hE0, 1'b1, 1'b1, 6, KIND_INCOMPLETE, 8'h00),
      word_row(8'h0B, 1'b0, 1'b0, 0, KIND_SYMBOL,     8'h00),
      word_row(8'hDF, 1'b0, 1'b0, 0, KIND_SYMBOL,     8'h00),
      word_row(8'h0F, 1'b1, 1'b1, 1, KIND_END,        8'h00),
      cfg_row(16'd0),
      word_row(8'h00, 1'b0, 1'b1, 1, KIND_LIMIT,      8'h00),
      word_row(8'hFF, 1'b1, 1'b1, 0, KIND_SYMBOL,     8'h00),
      cfg_row(16'd2),
      word_row(8'h00, 1'b0, 1'b1, 3, KIND_LIMIT,      8'h00),
      word_row(8'h00, 1'b1, 1'b1, 0, KIND_SYMBOL,     8'h00),
      cfg_row(16'hFFFF),
      word_row(8'h3F, 1'b1, 1'b1, 1, KIND_END,        8'h00),
      cfg_row(16'd255),
      word_row(8'h00, 1'b0, 1'b0, 0, KIND_SYMBOL,     8'h00),
      // lower the limit below the symbols already decoded in this run
      cfg_row(16'd3),
      word_row(8'h00, 1'b0, 1'b1, 1, KIND_LIMIT,      8'h00),
      word_row(8'h00, 1'b1, 1'b1, 0, KIND_SYMBOL,     8'h00),
      cfg_row(16'd255)
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_limit(plan[i].limit);
      end else begin
        push_word(plan[i].data, plan[i].fin, got);
        if (plan[i].known && (got != int'(plan[i].count) || (got > 0 &&
            (pending_results[pending_results.size()-1].kind != plan[i].last_kind ||
             pending_results[pending_results.size()-1].character != plan[i].last_char))))
        begin
          flag_error($sformatf("table row %0d: model gives %0d words", i, got));
        end
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       lim = 16'd255;
        1:       lim = 16'd1;
        2:       lim = 16'd0;
        3:       lim = 16'hFFFF;
        4:       lim = 16'($urandom_range(2, 12));
        5:       lim = 16'($urandom_range(3, 40));
        6:       lim = 16'($urandom);
        default: lim = 16'($urandom_range(13, 30));
      endcase
      wait_idle();
      write_limit(lim);
      idle_on <= (ph != 3);
      while (word_plan.size() < PhaseWords) build_message();
      // fill the block up behind a stalled receiver
      if (ph == 5) begin
        -> hold_start;
      end
      while (word_plan.size() > 0) begin
        w = word_plan.pop_front();
        push_word(w.data, w.fin, got);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
